/* design/tbrl_pkg.sv */
// ----------------------------------------------------------------------------
// tbrl_pkg
// Shared constants for the token bucket rate limiter: register indexes,
// command codes, reset values and divider geometry.
// ----------------------------------------------------------------------------
package tbrl_pkg;

	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BURST = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TPS   = 2'd2;

	localparam logic CMD_CHECK   = 1'b0;
	localparam logic CMD_RESTART = 1'b1;

	localparam int unsigned TPS_W = 17;

	localparam logic [31:0]      RATE_RST  = 32'd1048576;
	localparam logic [31:0]      BURST_RST = 32'd65536;
	localparam logic [TPS_W-1:0] TPS_RST   = 17'd1000;

	localparam logic [31:0] ALL32 = 32'hFFFF_FFFF;

	// shared divider: 64-bit dividend, 32-bit divisor, two quotient bits a cycle
	localparam int unsigned DIV_W      = 64;
	localparam int unsigned DVS_W      = 32;
	localparam int unsigned DIG_BITS   = 2;
	localparam int unsigned DIV_CYCLES = DIV_W / DIG_BITS;
	localparam int unsigned DCNT_W     = $clog2(DIV_CYCLES);

endpackage

/* design/token_bucket_rate_limiter.sv */
// ----------------------------------------------------------------------------
// token_bucket_rate_limiter
// Token bucket limiter: a request is refilled by elapsed*rate/ticks_per_second,
// capped at the burst size, then granted if the tokens cover its bytes,
// otherwise throttled with the wait time in ticks. A restart fills the bucket.
//
// A restart or a zero-byte request goes from idle straight to the done state,
// which passes its result to the output register once that is free. Others
// run multiply, refill divide, update, check; a throttled one then adds a
// multiply and divide for the wait time unless the rate is zero. Both share
// one restoring divider, two quotient bits a cycle over a 64-bit dividend.
// One item is in work at a time; a finished result waits in the output
// register while the next beat is taken. Configuration writes are always taken.
// ----------------------------------------------------------------------------
module token_bucket_rate_limiter #(
	parameter int unsigned COUNT_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,

	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tbrl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data,

	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           cmd,
	input  logic [31:0]                    now_tick,
	input  logic [31:0]                    request_bytes,

	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           throttled,
	output logic [31:0]                    wait_ticks,
	output logic [31:0]                    tokens_left
);

	localparam int unsigned CW = COUNT_WIDTH;
	localparam int unsigned WW = (CW > 32) ? CW : 32;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL1,
		S_DIV1,
		S_UPD,
		S_CHK,
		S_MUL2,
		S_DIV2,
		S_WQ,
		S_DONE
	} state_t;

	state_t state_q;

	// configuration
	logic [31:0]                  rate_q;
	logic [31:0]                  burst_q;
	logic [tbrl_pkg::TPS_W-1:0]   tps_q;

	// bucket state
	logic [CW-1:0]                token_q;
	logic [31:0]                  last_q;

	// item and datapath
	logic [31:0]                  now_q;
	logic [31:0]                  bytes_q;
	logic [31:0]                  deficit_q;
	logic [tbrl_pkg::DIV_W-1:0]   div_dq_q;
	logic [tbrl_pkg::DVS_W-1:0]   div_rem_q;
	logic [tbrl_pkg::DVS_W-1:0]   div_dvs_q;
	logic [tbrl_pkg::DCNT_W-1:0]  div_cnt_q;

	// pending and delivered result
	logic                         res_thr_q;
	logic [31:0]                  res_wait_q;
	logic                         out_valid_q;
	logic                         out_thr_q;
	logic [31:0]                  out_wait_q;
	logic [31:0]                  out_tok_q;

	// combinational
	logic [tbrl_pkg::TPS_W-1:0]   tps_eff;
	logic [31:0]                  elapsed;
	logic [CW-1:0]                cap;
	logic [CW-1:0]                headroom;
	logic                         fill_full;
	logic [CW-1:0]                token_fill;
	logic [WW-1:0]                tok_w;
	logic [WW-1:0]                bytes_w;
	logic                         covers;
	logic [31:0]                  tok_clip;
	logic [tbrl_pkg::DIV_W-1:0]   dq_n;
	logic [tbrl_pkg::DVS_W-1:0]   rem_n;
	logic [tbrl_pkg::DVS_W:0]     trial;
	logic                         ge;
	logic                         in_acc;
	logic                         slot_free;

	assign cfg_ready   = 1'b1;
	assign in_ready    = (state_q == S_IDLE);
	assign in_acc      = in_valid && in_ready;
	assign out_valid   = out_valid_q;
	assign throttled   = out_thr_q;
	assign wait_ticks  = out_wait_q;
	assign tokens_left = out_tok_q;
	assign slot_free   = !out_valid_q || out_ready;

	always_comb begin
		tps_eff    = (tps_q == '0) ? tbrl_pkg::TPS_W'(1) : tps_q;
		elapsed    = now_q - last_q;
		cap        = CW'(burst_q);
		headroom   = cap - token_q;
		fill_full  = (token_q >= cap) ||
			(div_dq_q >= tbrl_pkg::DIV_W'(headroom));
		token_fill = fill_full ? cap : (token_q + CW'(div_dq_q));
		tok_w      = WW'(token_q);
		bytes_w    = WW'(bytes_q);
		covers     = (tok_w >= bytes_w);
		tok_clip   = (tok_w > WW'(tbrl_pkg::ALL32)) ? tbrl_pkg::ALL32 : tok_w[31:0];
	end

	// restoring division, two bits a cycle
	always_comb begin
		rem_n = div_rem_q;
		dq_n  = div_dq_q;
		trial = '0;
		ge    = 1'b0;
		for (int i = 0; i < int'(tbrl_pkg::DIG_BITS); i++) begin
			trial = {rem_n, dq_n[tbrl_pkg::DIV_W-1]};
			ge    = (trial >= {1'b0, div_dvs_q});
			if (ge) begin
				trial = trial - {1'b0, div_dvs_q};
			end
			rem_n = trial[tbrl_pkg::DVS_W-1:0];
			dq_n  = {dq_n[tbrl_pkg::DIV_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q  <= tbrl_pkg::RATE_RST;
			burst_q <= tbrl_pkg::BURST_RST;
			tps_q   <= tbrl_pkg::TPS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tbrl_pkg::CFG_RATE:  rate_q  <= cfg_data;
				tbrl_pkg::CFG_BURST: burst_q <= cfg_data;
				tbrl_pkg::CFG_TPS:   tps_q   <= cfg_data[tbrl_pkg::TPS_W-1:0];
				default: ;
			endcase
		end
	end

	// item capture and divider datapath
	always_ff @(posedge clk) begin
		if (in_acc) begin
			now_q   <= now_tick;
			bytes_q <= request_bytes;
		end
		case (state_q)
			S_MUL1: begin
				div_dq_q  <= tbrl_pkg::DIV_W'(elapsed) * tbrl_pkg::DIV_W'(rate_q);
				div_rem_q <= '0;
				div_dvs_q <= tbrl_pkg::DVS_W'(tps_eff);
			end
			S_DIV1, S_DIV2: begin
				div_dq_q  <= dq_n;
				div_rem_q <= rem_n;
			end
			S_CHK: begin
				deficit_q <= 32'(bytes_w - tok_w);
			end
			S_MUL2: begin
				div_dq_q  <= tbrl_pkg::DIV_W'(deficit_q) * tbrl_pkg::DIV_W'(tps_eff);
				div_rem_q <= '0;
				div_dvs_q <= rate_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			token_q     <= CW'(tbrl_pkg::BURST_RST);
			last_q      <= '0;
			div_cnt_q   <= '0;
			res_thr_q   <= 1'b0;
			res_wait_q  <= '0;
			out_valid_q <= 1'b0;
			out_thr_q   <= 1'b0;
			out_wait_q  <= '0;
			out_tok_q   <= '0;
		end else begin
			if (state_q == S_DONE && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						res_thr_q  <= 1'b0;
						res_wait_q <= '0;
						if (cmd == tbrl_pkg::CMD_RESTART) begin
							token_q <= cap;
							last_q  <= now_tick;
							state_q <= S_DONE;
						end else if (request_bytes == '0) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_MUL1;
						end
					end
				end
				S_MUL1: begin
					div_cnt_q <= '0;
					state_q   <= S_DIV1;
				end
				S_DIV1: begin
					div_cnt_q <= div_cnt_q + tbrl_pkg::DCNT_W'(1);
					if (div_cnt_q == tbrl_pkg::DCNT_W'(tbrl_pkg::DIV_CYCLES - 1)) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					// quotient is the refill; a zero refill keeps the old tick
					if (div_dq_q != '0) begin
						token_q <= token_fill;
						last_q  <= now_q;
					end
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (covers) begin
						token_q <= CW'(tok_w - bytes_w);
						state_q <= S_DONE;
					end else if (rate_q == '0) begin
						res_thr_q  <= 1'b1;
						res_wait_q <= tbrl_pkg::ALL32;
						state_q    <= S_DONE;
					end else begin
						res_thr_q <= 1'b1;
						state_q   <= S_MUL2;
					end
				end
				S_MUL2: begin
					div_cnt_q <= '0;
					state_q   <= S_DIV2;
				end
				S_DIV2: begin
					div_cnt_q <= div_cnt_q + tbrl_pkg::DCNT_W'(1);
					if (div_cnt_q == tbrl_pkg::DCNT_W'(tbrl_pkg::DIV_CYCLES - 1)) begin
						state_q <= S_WQ;
					end
				end
				S_WQ: begin
					res_wait_q <= (div_dq_q >= tbrl_pkg::DIV_W'(tbrl_pkg::ALL32)) ?
						tbrl_pkg::ALL32 : (div_dq_q[31:0] + 32'd1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (slot_free) begin
						out_thr_q  <= res_thr_q;
						out_wait_q <= res_wait_q;
						out_tok_q  <= tok_clip;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// divider remainder stays below the divisor while dividing
	a_rem_below_dvs: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV1 || state_q == S_DIV2) |-> (div_rem_q < div_dvs_q))
		else $error("divider remainder not below divisor");

	a_restart_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && cmd == tbrl_pkg::CMD_RESTART) |=> (token_q == cap))
		else $error("restart did not fill the bucket");

	a_zero_bytes_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && cmd == tbrl_pkg::CMD_CHECK && request_bytes == '0)
		|=> ($stable(token_q) && $stable(last_q)))
		else $error("zero-byte request changed the bucket");

	a_refill_capped: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD && div_dq_q != '0) |=> (token_q <= cap))
		else $error("refill exceeded the burst size");

	a_grant_no_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_thr_q) |-> (out_wait_q == '0))
		else $error("granted beat carries a wait time");
`endif

endmodule

/* tb/token_bucket_rate_limiter_checker.sv */
// ----------------------------------------------------------------------------
// token_bucket_rate_limiter_checker
// Watches the config, request and result channels of the rate limiter, keeps
// its own bucket and register copies, predicts each result and compares it
// field by field with what comes out.
// ----------------------------------------------------------------------------
module token_bucket_rate_limiter_checker (
	input  logic                           clk,
	input  logic                           arst_n,

	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [tbrl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data,

	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic                           cmd,
	input  logic [31:0]                    now_tick,
	input  logic [31:0]                    request_bytes,

	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic                           throttled,
	input  logic [31:0]                    wait_ticks,
	input  logic [31:0]                    tokens_left,

	output int                             outstanding,
	output int                             fails
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic        refused;
		logic [31:0] delay;
		logic [31:0] left;
	} verdict_t;

	logic [31:0]                rate_reg;
	logic [31:0]                burst_reg;
	logic [tbrl_pkg::TPS_W-1:0] tps_reg;
	logic [31:0]                bucket_tokens;
	logic [31:0]                bucket_stamp;

	verdict_t verdict_q[$];
	int       fail_total = 0;

	initial begin
		outstanding = 0;
		fails = 0;
	end

	function automatic verdict_t predict_verdict(input logic c, input logic [31:0] now,
			input logic [31:0] bytes);
		verdict_t    v;
		logic [63:0] elapsed;
		logic [63:0] tps;
		logic [63:0] gain;
		logic [63:0] cap;
		logic [63:0] have;
		logic [63:0] deficit;
		logic [63:0] quot;
		v = '0;
		if (c == tbrl_pkg::CMD_RESTART) begin
			bucket_tokens = burst_reg;
			bucket_stamp = now;
		end else if (bytes != 32'd0) begin
			elapsed = {32'd0, now - bucket_stamp};
			tps = (tps_reg == '0) ? 64'd1 : {47'd0, tps_reg};
			gain = (elapsed * {32'd0, rate_reg}) / tps;
			cap = {32'd0, burst_reg};
			have = {32'd0, bucket_tokens};
			// stamp stays put on a zero refill so fractions carry over
			if (gain != 64'd0) begin
				if (have >= cap || gain >= cap - have)
					bucket_tokens = burst_reg;
				else
					bucket_tokens = bucket_tokens + gain[31:0];
				bucket_stamp = now;
			end
			if (bucket_tokens >= bytes) begin
				bucket_tokens = bucket_tokens - bytes;
			end else begin
				v.refused = 1'b1;
				deficit = {32'd0, bytes - bucket_tokens};
				if (rate_reg == 32'd0) begin
					v.delay = tbrl_pkg::ALL32;
				end else begin
					quot = (deficit * tps) / {32'd0, rate_reg};
					v.delay = (quot >= {32'd0, tbrl_pkg::ALL32}) ?
						tbrl_pkg::ALL32 : quot[31:0] + 32'd1;
				end
			end
		end
		v.left = bucket_tokens;
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		if (!arst_n) begin
			rate_reg = tbrl_pkg::RATE_RST;
			burst_reg = tbrl_pkg::BURST_RST;
			tps_reg = tbrl_pkg::TPS_RST;
			bucket_tokens = tbrl_pkg::BURST_RST;
			bucket_stamp = '0;
			verdict_q.delete();
			outstanding <= 0;
		end else begin
			// result beat first: it belongs to an earlier request
			if (out_valid && out_ready) begin
				if (verdict_q.size() == 0) begin
					$display("%0t: result beat with nothing expected: %s %0d %0h %0h",
						$time, "throttled, wait, tokens", throttled, wait_ticks,
						tokens_left);
					fail_total++;
				end else begin
					want = verdict_q.pop_front();
					if (throttled !== want.refused) begin
						$display("%0t: throttled expected %0d actual %0d",
							$time, want.refused, throttled);
						fail_total++;
					end
					if (wait_ticks !== want.delay) begin
						$display("%0t: wait_ticks expected %0h actual %0h",
							$time, want.delay, wait_ticks);
						fail_total++;
					end
					if (tokens_left !== want.left) begin
						$display("%0t: tokens_left expected %0h actual %0h",
							$time, want.left, tokens_left);
						fail_total++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					tbrl_pkg::CFG_RATE:  rate_reg = cfg_data;
					tbrl_pkg::CFG_BURST: burst_reg = cfg_data;
					tbrl_pkg::CFG_TPS:   tps_reg = cfg_data[tbrl_pkg::TPS_W-1:0];
					default:   ;
				endcase
			end
			if (in_valid && in_ready)
				verdict_q.push_back(predict_verdict(cmd, now_tick, request_bytes));
			outstanding <= verdict_q.size();
		end
		fails <= fail_total;
	end

endmodule

/* tb/token_bucket_rate_limiter_test.sv */
// ----------------------------------------------------------------------------
// token_bucket_rate_limiter_test
// Drives the rate limiter with directed corner requests and random request
// streams under several register settings, with random stalls on both sides
// and two long result back-pressure stretches; the checker judges every result.
// ----------------------------------------------------------------------------
module token_bucket_rate_limiter_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [tbrl_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam int PHASE_ITEMS = 165;
	localparam int HOLD_CYCLES = 400;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [tbrl_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [31:0]                    cfg_data;
	logic                           in_valid;
	logic                           in_ready;
	logic                           cmd;
	logic [31:0]                    now_tick;
	logic [31:0]                    request_bytes;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic                           throttled;
	logic [31:0]                    wait_ticks;
	logic [31:0]                    tokens_left;
	int                             outstanding;
	int                             fails;

	int          snd_idle = 0;
	int          rcv_idle = 0;
	int          hold_reqs = 0;
	int          hold_seen = 0;
	int          hold_left = 0;
	int          beats = 0;
	logic [31:0] tick = '0;
	logic [31:0] cur_rate = tbrl_pkg::RATE_RST;
	logic [31:0] cur_burst = tbrl_pkg::BURST_RST;
	logic [31:0] cur_tps = 32'(tbrl_pkg::TPS_RST);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	token_bucket_rate_limiter uut (.*);

	token_bucket_rate_limiter_checker chk (.*);

	// result side: random stalls, plus long hold-offs on request
	always @(posedge clk) begin
		if (hold_seen != hold_reqs) begin
			hold_seen = hold_reqs;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rcv_idle);
		end
	end

	task automatic write_reg(input logic [tbrl_pkg::CFG_IDX_W-1:0] idx,
			input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			tbrl_pkg::CFG_RATE:  cur_rate = data;
			tbrl_pkg::CFG_BURST: cur_burst = data;
			tbrl_pkg::CFG_TPS:   cur_tps = 32'(data[tbrl_pkg::TPS_W-1:0]);
			default:   ;
		endcase
	endtask

	// leaves valid high after the beat so back-to-back requests need no gap
	task automatic offer(input logic c, input logic [31:0] t, input logic [31:0] b);
		if (beats < 390) begin
			snd_idle = 16;
			rcv_idle <= 77;
		end else if (beats < 780) begin
			snd_idle = 77;
			rcv_idle <= 16;
		end else begin
			snd_idle = 0;
			rcv_idle <= 0;
		end
		while ($urandom_range(99) < snd_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		now_tick <= t;
		request_bytes <= b;
		do @(posedge clk); while (!in_ready);
		beats++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic random_item();
		logic        c;
		logic [31:0] step;
		logic [31:0] b;
		logic [31:0] span;
		c = ($urandom_range(99) < 4) ? tbrl_pkg::CMD_RESTART : tbrl_pkg::CMD_CHECK;
		case ($urandom_range(15))
			0:       step = $urandom;
			1, 2, 3: step = '0;
			4:       step = $urandom_range(1, 3);
			default: step = $urandom_range(0, cur_tps / 8 + 2);
		endcase
		span = (cur_burst >> 1) + 32'd1;
		case ($urandom_range(15))
			0:       b = '0;
			1:       b = $urandom;
			2:       b = $urandom_range(1, 8);
			default: b = $urandom_range(1, span);
		endcase
		tick = tick + step;
		offer(c, tick, b);
	endtask

	initial begin
		#4ms;
		$display("token_bucket_rate_limiter_test NOT OK");
		$finish;
	end

	initial begin
		logic [31:0] rate_set[7];
		logic [31:0] burst_set[7];
		logic [31:0] tps_set[7];
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= tbrl_pkg::CFG_RATE;
		cfg_data <= '0;
		in_valid <= 1'b0;
		cmd <= tbrl_pkg::CMD_CHECK;
		now_tick <= '0;
		request_bytes <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: bucket full, stamp at zero
		offer(tbrl_pkg::CMD_CHECK, 32'd0, 32'd0);             // zero bytes change nothing
		offer(tbrl_pkg::CMD_CHECK, 32'd0, 32'd1);             // no time elapsed
		offer(tbrl_pkg::CMD_CHECK, 32'd0, 32'd65535);         // empties the bucket
		offer(tbrl_pkg::CMD_CHECK, 32'd0, 32'd1);             // short wait
		offer(tbrl_pkg::CMD_CHECK, 32'd0, tbrl_pkg::ALL32);   // long wait
		offer(tbrl_pkg::CMD_CHECK, 32'd1, 32'd2000);          // one tick refills a fraction
		offer(tbrl_pkg::CMD_RESTART, 32'hFFFF_FFF0, tbrl_pkg::ALL32); // bytes ignored
		offer(tbrl_pkg::CMD_CHECK, 32'hFFFF_FFF0, 32'd65536); // exact fit
		offer(tbrl_pkg::CMD_CHECK, 32'h0000_0010, 32'd100);   // elapsed across tick wrap
		offer(tbrl_pkg::CMD_RESTART, 32'h0000_0010, 32'd0);
		drain();

		// cap lowered below the count, next real refill clamps it
		write_reg(tbrl_pkg::CFG_BURST, 32'd100);
		offer(tbrl_pkg::CMD_CHECK, 32'h0000_0020, 32'd1);
		offer(tbrl_pkg::CMD_CHECK, 32'h0000_0020, 32'd200);
		drain();

		write_reg(tbrl_pkg::CFG_RATE, 32'd0);
		offer(tbrl_pkg::CMD_CHECK, 32'h0000_1000, 32'd500);   // zero rate saturates the wait
		drain();

		write_reg(tbrl_pkg::CFG_RATE, tbrl_pkg::ALL32);
		write_reg(tbrl_pkg::CFG_BURST, tbrl_pkg::ALL32);
		write_reg(tbrl_pkg::CFG_TPS, tbrl_pkg::ALL32);
		offer(tbrl_pkg::CMD_RESTART, 32'd0, 32'd0);
		offer(tbrl_pkg::CMD_CHECK, 32'd0, tbrl_pkg::ALL32);
		offer(tbrl_pkg::CMD_CHECK, 32'd0, tbrl_pkg::ALL32);
		offer(tbrl_pkg::CMD_CHECK, 32'd5, 32'd12345);
		drain();

		write_reg(tbrl_pkg::CFG_RATE, 32'd1);
		offer(tbrl_pkg::CMD_CHECK, 32'd6, tbrl_pkg::ALL32);   // huge quotient saturates
		drain();

		write_reg(tbrl_pkg::CFG_TPS, 32'd0);                  // zero scale behaves as one
		write_reg(tbrl_pkg::CFG_BURST, 32'd10);
		offer(tbrl_pkg::CMD_CHECK, 32'd9, 32'd3);
		offer(tbrl_pkg::CMD_CHECK, 32'd12, 32'd20);
		drain();
		write_reg(CFG_SPARE, $urandom);

		rate_set = '{tbrl_pkg::RATE_RST, 32'd1, tbrl_pkg::ALL32, 32'd0,
			$urandom_range(1, 1 << 24), 32'd3, 32'd50000};
		burst_set = '{tbrl_pkg::BURST_RST, 32'd1000, tbrl_pkg::ALL32, 32'd5000,
			$urandom_range(0, 1 << 20), 32'd0, 32'd200000};
		tps_set = '{32'(tbrl_pkg::TPS_RST), 32'd1, 32'h0001_FFFF, 32'd100000,
			$urandom_range(1, 100000), 32'd0, 32'd1000};
		tick = $urandom;

		for (int p = 0; p < 7; p++) begin
			drain();
			write_reg(tbrl_pkg::CFG_RATE, rate_set[p]);
			write_reg(tbrl_pkg::CFG_BURST, burst_set[p]);
			write_reg(tbrl_pkg::CFG_TPS, tps_set[p]);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// long result hold-off while requests keep coming
				if ((p == 1 || p == 6) && k == 60)
					hold_reqs <= hold_reqs + 1;
				random_item();
			end
		end

		drain();
		repeat (100) @(posedge clk);
		if (fails == 0 && outstanding == 0)
			$display("token_bucket_rate_limiter_test OK");
		else
			$display("token_bucket_rate_limiter_test NOT OK");
		$finish;
	end

endmodule

/* filelist.f */
design/tbrl_pkg.sv
design/token_bucket_rate_limiter.sv
tb/token_bucket_rate_limiter_checker.sv
tb/token_bucket_rate_limiter_test.sv
